[rtl/hss_pkg.sv]
// Package with shared types and constants of the Hilbert spatial sort block.
package hss_pkg;

  localparam int MAX_FEATURES_DEF = 64;
  localparam int CURVE_ORDER_DEF  = 16;
  localparam int COORD_W          = 32;
  localparam int SUM_W            = 33;
  localparam int KEY_W            = 32;
  localparam int IDX_W            = 6;
  localparam int CELL_W           = 16;
  localparam int NUM_W            = 50;
  localparam int DIV_STEPS        = 16;

  typedef struct packed {
    logic             valid;
    logic             flag;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } hss_entry_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_READ,
    S_PREP,
    S_DIV,
    S_HLD,
    S_HIL,
    S_INS,
    S_OUT
  } hss_state_t;

endpackage

[rtl/hss_grid_div.sv]
// Grid cell unit: clamps a centre into the extent and divides bit by bit.
module hss_grid_div
  import hss_pkg::*;
(
  input  logic                      clk,
  input  logic                      start,
  input  logic                      step,
  input  logic signed [SUM_W-1:0]   sum,
  input  logic signed [COORD_W-1:0] lo,
  input  logic signed [COORD_W-1:0] hi,
  output logic [CELL_W-1:0]         grid_idx
);

  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  dsh_r, dsh_nxt;
  logic [CELL_W-1:0] q_r, q_nxt;
  logic              zero_r, zero_nxt;

  logic signed [34:0] w;
  logic signed [34:0] w2;
  logic signed [34:0] d;
  logic [33:0]        dcl;
  logic               ge;

  always_comb begin
    w   = 35'(hi) - 35'(lo);
    w2  = w <<< 1;
    d   = 35'(sum) - (35'(lo) <<< 1);
    if (d < 0) begin
      dcl = '0;
    end else if (d > w2) begin
      dcl = w2[33:0];
    end else begin
      dcl = d[33:0];
    end
    ge       = rem_r >= dsh_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    zero_nxt = zero_r;
    if (start) begin
      // 65534 * d is formed as 65536 * d - 2 * d.
      rem_nxt  = (NUM_W'(dcl) << 16) - (NUM_W'(dcl) << 1) + NUM_W'(w[33:0]);
      dsh_nxt  = NUM_W'(w2[33:0]) << (DIV_STEPS - 1);
      q_nxt    = '0;
      zero_nxt = (w <= 0);
    end else if (step) begin
      rem_nxt = ge ? (rem_r - dsh_r) : rem_r;
      dsh_nxt = dsh_r >> 1;
      q_nxt   = {q_r[CELL_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    zero_r <= zero_nxt;
  end

  assign grid_idx = zero_r ? '0 : q_r;

endmodule

[rtl/hss_sort_cell.sv]
// One cell of the insertion sort chain; also shifts toward the head on output.
module hss_sort_cell
  import hss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       ins,
  input  logic       shift,
  input  hss_entry_t new_e,
  input  hss_entry_t prev_e,
  input  logic       prev_p,
  input  hss_entry_t next_e,
  output hss_entry_t cur_e,
  output logic       p
);

  hss_entry_t cur_r, cur_nxt;

  // The new entry goes ahead if the cell is empty, if only it is flagged, or if
  // both are flagged and it is lower; equal keys stay in arrival order.
  assign p = !cur_r.valid ||
             (new_e.flag && (!cur_r.flag || (new_e.key < cur_r.key)));

  always_comb begin
    cur_nxt = cur_r;
    if (ins && p) begin
      cur_nxt = prev_p ? prev_e : new_e;
    end else if (shift) begin
      cur_nxt = next_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

  assign cur_e = cur_r;

endmodule

[rtl/hilbert_spatial_sort.sv]
// Top level of the Hilbert spatial sort: load, key unit, sort chain, output.
//
// Features arrive on the in_ channel, one per beat, while the block is loading.
// Each beat is stored and, if it has an envelope, widens the running extent;
// in_ready drops after the beat that carries in_batch_end. Beats past
// MAX_FEATURES are dropped and set out_overflow for the batch. Keys are then
// formed one feature at a time: one memory read, a setup step, DIV_STEPS
// divider steps shared by both axes in parallel, a load step, CURVE_ORDER
// Hilbert steps and one insert into the sort chain. The sorted batch then
// leaves the head of the chain at one beat per cycle, last_out marking its
// final beat; a stalled receiver simply holds the chain. After the final beat
// the block takes a new batch. Reset empties the chain and the extent and
// returns to loading.
module hilbert_spatial_sort
  import hss_pkg::*;
#(
  parameter int MAX_FEATURES = MAX_FEATURES_DEF,
  parameter int CURVE_ORDER  = CURVE_ORDER_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_has_envelope,
  input  logic signed [COORD_W-1:0] in_min_x,
  input  logic signed [COORD_W-1:0] in_min_y,
  input  logic signed [COORD_W-1:0] in_max_x,
  input  logic signed [COORD_W-1:0] in_max_y,
  input  logic                      in_batch_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          out_feature_index,
  output logic [KEY_W-1:0]          out_sort_key,
  output logic                      out_key_valid,
  output logic                      out_overflow,
  output logic                      out_last_out
);

  localparam int AW    = $clog2(MAX_FEATURES);
  localparam int CNT_W = $clog2(MAX_FEATURES + 1);
  localparam int MEM_W = 1 + 2 * SUM_W;

  hss_state_t state_r, state_nxt;

  logic [CNT_W-1:0]          count_r;
  logic                      ovf_r;
  logic                      seen_r;
  logic signed [COORD_W-1:0] lox_r, loy_r, hix_r, hiy_r;
  logic [AW-1:0]             kidx_r;
  logic [3:0]                cnt_r;
  logic [3:0]                bit_r;
  logic [CELL_W-1:0]         hx_r, hy_r;
  logic [KEY_W-1:0]          key_r;

  logic [MEM_W-1:0] mem [MAX_FEATURES];
  logic [MEM_W-1:0] rd_r;

  logic in_acc, out_acc, room, last_key;
  logic ins, shift, div_start, div_step;
  logic [CELL_W-1:0] cell_x, cell_y;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign room     = count_r < CNT_W'(MAX_FEATURES);
  assign last_key = (CNT_W'(kidx_r) + CNT_W'(1)) == count_r;

  hss_entry_t cells [MAX_FEATURES];
  logic       pv    [MAX_FEATURES];
  hss_entry_t new_e;

  always_comb begin
    new_e.valid = 1'b1;
    new_e.flag  = rd_r[MEM_W-1];
    new_e.key   = rd_r[MEM_W-1] ? key_r : '0;
    new_e.idx   = IDX_W'(kidx_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: if (in_acc && in_batch_end) state_nxt = S_READ;
      S_READ: state_nxt = S_PREP;
      S_PREP: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 4'(DIV_STEPS - 1)) state_nxt = S_HLD;
      S_HLD:  state_nxt = S_HIL;
      S_HIL:  if (bit_r == 4'd0) state_nxt = S_INS;
      S_INS:  state_nxt = last_key ? S_OUT : S_READ;
      S_OUT:  if (out_acc && !cells[1].valid) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = (state_r == S_LOAD);
    out_valid = (state_r == S_OUT);
    div_start = (state_r == S_PREP);
    div_step  = (state_r == S_DIV);
    ins       = (state_r == S_INS);
    shift     = out_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Load side: extent, counts and the feature store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      seen_r  <= 1'b0;
      lox_r   <= '0;
      loy_r   <= '0;
      hix_r   <= '0;
      hiy_r   <= '0;
    end else if (out_acc && !cells[1].valid) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      seen_r  <= 1'b0;
      lox_r   <= '0;
      loy_r   <= '0;
      hix_r   <= '0;
      hiy_r   <= '0;
    end else if (in_acc) begin
      if (!room) begin
        ovf_r <= 1'b1;
      end else begin
        count_r <= count_r + CNT_W'(1);
        if (in_has_envelope) begin
          seen_r <= 1'b1;
          if (!seen_r || in_min_x < lox_r) lox_r <= in_min_x;
          if (!seen_r || in_min_y < loy_r) loy_r <= in_min_y;
          if (!seen_r || in_max_x > hix_r) hix_r <= in_max_x;
          if (!seen_r || in_max_y > hiy_r) hiy_r <= in_max_y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      mem[count_r[AW-1:0]] <= {in_has_envelope,
                               SUM_W'(in_min_x) + SUM_W'(in_max_x),
                               SUM_W'(in_min_y) + SUM_W'(in_max_y)};
    end
    if (state_r == S_READ) begin
      rd_r <= mem[kidx_r];
    end
  end

  hss_grid_div u_div_x (
    .clk      (clk),
    .start    (div_start),
    .step     (div_step),
    .sum      (rd_r[2*SUM_W-1:SUM_W]),
    .lo       (lox_r),
    .hi       (hix_r),
    .grid_idx (cell_x)
  );

  hss_grid_div u_div_y (
    .clk      (clk),
    .start    (div_start),
    .step     (div_step),
    .sum      (rd_r[SUM_W-1:0]),
    .lo       (loy_r),
    .hi       (hiy_r),
    .grid_idx (cell_y)
  );

  // Key unit sequencing and one Hilbert bit per cycle, top bit first.
  logic rx, ry;
  logic [CELL_W-1:0] tx, ty;

  always_comb begin
    rx = hx_r[bit_r];
    ry = hy_r[bit_r];
    tx = hx_r;
    ty = hy_r;
    if (!ry) begin
      if (rx) begin
        tx = ~hx_r;
        ty = ~hy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kidx_r <= '0;
      cnt_r  <= '0;
      bit_r  <= '0;
    end else begin
      if (state_r == S_LOAD) kidx_r <= '0;
      else if (state_r == S_INS) kidx_r <= kidx_r + AW'(1);
      if (state_r == S_DIV) cnt_r <= cnt_r + 4'd1;
      else cnt_r <= '0;
      if (state_r == S_HLD) bit_r <= 4'(CURVE_ORDER - 1);
      else if (state_r == S_HIL) bit_r <= bit_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_HLD) begin
      hx_r  <= cell_x;
      hy_r  <= cell_y;
      key_r <= '0;
    end else if (state_r == S_HIL) begin
      key_r <= {key_r[KEY_W-3:0], rx, rx ^ ry};
      if (!ry) begin
        hx_r <= ty;
        hy_r <= tx;
      end
    end
  end

  // Sort chain; the head cell is the output register.
  for (genvar i = 0; i < MAX_FEATURES; i++) begin : g_cell
    hss_entry_t prev_e, next_e;
    logic       prev_p;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_p = 1'b0;
    end else begin : g_body
      assign prev_e = cells[i-1];
      assign prev_p = pv[i-1];
    end
    if (i == MAX_FEATURES - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = cells[i+1];
    end
    hss_sort_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ins    (ins),
      .shift  (shift),
      .new_e  (new_e),
      .prev_e (prev_e),
      .prev_p (prev_p),
      .next_e (next_e),
      .cur_e  (cells[i]),
      .p      (pv[i])
    );
  end

  assign out_feature_index = cells[0].idx;
  assign out_sort_key      = cells[0].key;
  assign out_key_valid     = cells[0].flag;
  assign out_overflow      = ovf_r;
  assign out_last_out      = !cells[1].valid;

endmodule
